>>> design/i2cbe_pkg.sv
// i2cbe_pkg: shared types, codes and line-drive table for the i2c master byte engine
// no dependencies; imported by every module of the engine
package i2cbe_pkg;

    localparam int unsigned TDATA_W = 16;

    // command codes
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_WRITE   = 3'd2;
    localparam logic [2:0] CMD_READ    = 3'd3;
    localparam logic [2:0] CMD_STOP    = 3'd4;
    localparam logic [2:0] CMD_RELEASE = 3'd5;

    // configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_STRETCH     = 1'b1;

    localparam logic [7:0] HALF_PERIOD_RST = 8'd6;
    localparam logic [7:0] STRETCH_RST     = 8'd255;
    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
    localparam logic [3:0] RELEASE_CLOCKS  = 4'd15;
    localparam logic [3:0] CHECK_SAMPLES   = 4'd5;

    // phase codes
    localparam logic [4:0] PH_IDLE     = 5'd0;
    localparam logic [4:0] PH_ST_A     = 5'd1;
    localparam logic [4:0] PH_ST_B     = 5'd2;
    localparam logic [4:0] PH_ST_C     = 5'd3;
    localparam logic [4:0] PH_WB_LOW   = 5'd4;
    localparam logic [4:0] PH_WB_HIGH  = 5'd5;
    localparam logic [4:0] PH_WA_LOW   = 5'd6;
    localparam logic [4:0] PH_WA_HIGH  = 5'd7;
    localparam logic [4:0] PH_WA_END   = 5'd8;
    localparam logic [4:0] PH_RD_LOW   = 5'd9;
    localparam logic [4:0] PH_RD_HIGH  = 5'd10;
    localparam logic [4:0] PH_RA_LOW   = 5'd11;
    localparam logic [4:0] PH_RA_HIGH  = 5'd12;
    localparam logic [4:0] PH_RA_END   = 5'd13;
    localparam logic [4:0] PH_SP_A     = 5'd14;
    localparam logic [4:0] PH_SP_B     = 5'd15;
    localparam logic [4:0] PH_SP_C     = 5'd16;
    localparam logic [4:0] PH_BR_LOW   = 5'd17;
    localparam logic [4:0] PH_BR_HIGH  = 5'd18;
    localparam logic [4:0] PH_BR_CHECK = 5'd19;

    typedef struct packed {
        logic       sda_in;
        logic       scl_in;
        logic       stop_after;
        logic [7:0] tx_byte;
        logic [2:0] cmd;
    } t_item;

    typedef struct packed {
        logic       stretch_timeout;
        logic       nack_seen;
        logic [7:0] rx_byte;
        logic       success;
        logic       done_res;
        logic       busy_res;
        logic       sda_pull_low;
        logic       scl_pull_low;
    } t_result;

    // line drive on entry to a phase: bit 0 scl low, bit 1 sda low
    function automatic logic [1:0] drive_of(input logic [4:0] ph, input logic tx_msb,
                                            input logic stop_latch);
        logic scl;
        logic sda;
        scl = 1'b0;
        sda = 1'b0;
        case (ph)
            PH_ST_B:    sda = 1'b1;
            PH_ST_C:    begin scl = 1'b1; sda = 1'b1; end
            PH_WB_LOW:  begin scl = 1'b1; sda = ~tx_msb; end
            PH_WB_HIGH: sda = ~tx_msb;
            PH_WA_LOW, PH_WA_END, PH_RD_LOW, PH_RA_END, PH_BR_LOW: scl = 1'b1;
            PH_RA_LOW:  begin scl = 1'b1; sda = ~stop_latch; end
            PH_RA_HIGH: sda = ~stop_latch;
            PH_SP_A:    begin scl = 1'b1; sda = 1'b1; end
            PH_SP_B:    sda = 1'b1;
            default:    ;
        endcase
        return {sda, scl};
    endfunction

endpackage

>>> design/i2cbe_front.sv
// i2cbe_front: unpacks an incoming tick and classifies its command
// depends on i2cbe_pkg
module i2cbe_front (
    input  logic [i2cbe_pkg::TDATA_W-1:0] i_tdata,
    output i2cbe_pkg::t_item              o_item
);
    import i2cbe_pkg::*;

    logic [2:0] w_cmd;

    assign w_cmd = i_tdata[2:0];

    always_comb begin
        o_item.tx_byte    = i_tdata[10:3];
        o_item.stop_after = i_tdata[11];
        o_item.scl_in     = i_tdata[12];
        o_item.sda_in     = i_tdata[13];
        unique case (w_cmd)
            CMD_START, CMD_WRITE, CMD_READ, CMD_STOP, CMD_RELEASE: o_item.cmd = w_cmd;
            default: o_item.cmd = CMD_NONE;
        endcase
    end

endmodule

>>> design/i2cbe_queue.sv
// i2cbe_queue: two-entry queue of classified ticks between front and core
// depends on i2cbe_pkg
module i2cbe_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  i2cbe_pkg::t_item    i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output i2cbe_pkg::t_item    o_item
);
    import i2cbe_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> design/i2cbe_core.sv
// i2cbe_core: bit-level bus sequencer, one tick per queued item, with output register
// depends on i2cbe_pkg
module i2cbe_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_valid,
    input  i2cbe_pkg::t_item    i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output i2cbe_pkg::t_result  o_result
);
    import i2cbe_pkg::*;

    logic [7:0] r_half;
    logic [7:0] r_limit;
    logic [4:0] r_phase,   n_phase;
    logic [3:0] r_bit,     n_bit;
    logic [7:0] r_delay,   n_delay;
    logic [7:0] r_stretch, n_stretch;
    logic [7:0] r_tx,      n_tx;
    logic [7:0] r_rx,      n_rx;
    logic [1:0] r_err,     n_err;
    logic       r_stop,    n_stop;
    logic [1:0] r_drive,   n_drive;
    logic       r_out_valid;
    t_result    r_out,     n_out;
    logic       w_done;
    logic       w_ok;
    logic       w_enter;
    logic [7:0] w_delay_inc;
    logic [7:0] w_stretch_inc;
    logic [3:0] w_bit_inc;
    logic       w_stretch_ph;

    assign o_pop         = i_valid && (!r_out_valid || i_ready);
    assign o_valid       = r_out_valid;
    assign o_result      = r_out;
    assign w_delay_inc   = r_delay + 8'd1;
    assign w_stretch_inc = r_stretch + 8'd1;
    assign w_bit_inc     = r_bit + 4'd1;
    assign w_stretch_ph  = (r_phase == PH_WB_HIGH) || (r_phase == PH_WA_HIGH) ||
                           (r_phase == PH_RD_HIGH) || (r_phase == PH_RA_HIGH) ||
                           (r_phase == PH_SP_B);

    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_delay   = r_delay;
        n_stretch = r_stretch;
        n_tx      = r_tx;
        n_rx      = r_rx;
        n_err     = r_err;
        n_stop    = r_stop;
        n_drive   = r_drive;
        w_done    = 1'b0;
        w_ok      = 1'b0;
        w_enter   = 1'b0;

        if (r_phase == PH_IDLE || r_phase > PH_BR_CHECK) begin
            n_phase = PH_IDLE;
            n_drive = 2'b00;
            n_bit   = 4'd0;
            unique case (i_item.cmd)
                CMD_START: begin
                    n_err = 2'b00; n_tx = i_item.tx_byte; n_stop = 1'b0;
                    n_phase = PH_ST_A; w_enter = 1'b1;
                end
                CMD_WRITE: begin
                    n_tx = i_item.tx_byte; n_stop = i_item.stop_after;
                    n_phase = PH_WB_LOW; w_enter = 1'b1;
                end
                CMD_READ: begin
                    n_stop = i_item.stop_after; n_phase = PH_RD_LOW; w_enter = 1'b1;
                end
                CMD_STOP:    begin n_phase = PH_SP_A;   w_enter = 1'b1; end
                CMD_RELEASE: begin n_phase = PH_BR_LOW; w_enter = 1'b1; end
                default: ;
            endcase
        end else if (r_phase == PH_BR_CHECK) begin
            if (i_item.sda_in) begin
                w_done = 1'b1;
                w_ok   = 1'b1;
            end else begin
                n_bit = w_bit_inc;
                if (w_bit_inc >= CHECK_SAMPLES) begin
                    w_done = 1'b1;
                end
            end
        end else if (w_stretch_ph && r_delay == 8'd0 && !i_item.scl_in) begin
            n_stretch = w_stretch_inc;
            if (w_stretch_inc == r_limit) begin
                n_err[1] = 1'b1;
                n_phase  = (r_phase == PH_SP_B) ? PH_SP_C : PH_SP_A;
                w_enter  = 1'b1;
            end
        end else begin
            n_delay = w_delay_inc;
            if (w_delay_inc == r_half) begin
                w_enter = 1'b1;
                unique case (r_phase)
                    PH_ST_A:   n_phase = PH_ST_B;
                    PH_ST_B:   n_phase = PH_ST_C;
                    PH_ST_C:   begin n_bit = 4'd0; n_phase = PH_WB_LOW; end
                    PH_WB_LOW: n_phase = PH_WB_HIGH;
                    PH_WB_HIGH: begin
                        n_tx    = {r_tx[6:0], 1'b0};
                        n_bit   = w_bit_inc;
                        n_phase = (w_bit_inc >= BITS_PER_BYTE) ? PH_WA_LOW : PH_WB_LOW;
                    end
                    PH_WA_LOW: n_phase = PH_WA_HIGH;
                    PH_WA_HIGH: begin
                        if (i_item.sda_in) begin
                            n_err[0] = 1'b1;
                        end
                        n_phase = PH_WA_END;
                    end
                    PH_WA_END: begin
                        if (r_stop || r_err != 2'b00) begin
                            n_phase = PH_SP_A;
                        end else begin
                            w_enter = 1'b0; w_done = 1'b1; w_ok = 1'b1;
                        end
                    end
                    PH_RD_LOW: n_phase = PH_RD_HIGH;
                    PH_RD_HIGH: begin
                        n_rx    = {r_rx[6:0], i_item.sda_in};
                        n_bit   = w_bit_inc;
                        n_phase = (w_bit_inc >= BITS_PER_BYTE) ? PH_RA_LOW : PH_RD_LOW;
                    end
                    PH_RA_LOW:  n_phase = PH_RA_HIGH;
                    PH_RA_HIGH: n_phase = PH_RA_END;
                    PH_RA_END: begin
                        if (r_stop) begin
                            n_phase = PH_SP_A;
                        end else begin
                            w_enter = 1'b0; w_done = 1'b1; w_ok = (r_err == 2'b00);
                        end
                    end
                    PH_SP_A: n_phase = PH_SP_B;
                    PH_SP_B: n_phase = PH_SP_C;
                    PH_SP_C: begin
                        if (r_bit == RELEASE_CLOCKS) begin
                            n_bit = 4'd0; n_phase = PH_BR_CHECK;
                        end else begin
                            w_enter = 1'b0; w_done = 1'b1; w_ok = (r_err == 2'b00);
                        end
                    end
                    PH_BR_LOW: n_phase = PH_BR_HIGH;
                    PH_BR_HIGH: begin
                        n_bit   = w_bit_inc;
                        n_phase = (w_bit_inc >= RELEASE_CLOCKS) ? PH_SP_A : PH_BR_LOW;
                    end
                    default: w_enter = 1'b0;
                endcase
            end
        end

        if (w_enter) begin
            n_delay   = 8'd0;
            n_stretch = 8'd0;
            n_drive   = drive_of(n_phase, n_tx[7], n_stop);
        end

        if (w_done) begin
            n_phase   = PH_IDLE;
            n_drive   = 2'b00;
            n_delay   = 8'd0;
            n_stretch = 8'd0;
            n_bit     = 4'd0;
        end

        n_out.scl_pull_low    = n_drive[0];
        n_out.sda_pull_low    = n_drive[1];
        n_out.busy_res        = (n_phase != PH_IDLE);
        n_out.done_res        = w_done;
        n_out.success         = w_done && w_ok;
        n_out.rx_byte         = n_rx;
        n_out.nack_seen       = n_err[0];
        n_out.stretch_timeout = n_err[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= HALF_PERIOD_RST;
            r_limit     <= STRETCH_RST;
            r_phase     <= PH_IDLE;
            r_bit       <= 4'd0;
            r_delay     <= 8'd0;
            r_stretch   <= 8'd0;
            r_tx        <= 8'd0;
            r_rx        <= 8'd0;
            r_err       <= 2'b00;
            r_stop      <= 1'b0;
            r_drive     <= 2'b00;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_HALF_PERIOD: r_half  <= i_cfg_data;
                    CFG_STRETCH:     r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_pop) begin
                r_phase     <= n_phase;
                r_bit       <= n_bit;
                r_delay     <= n_delay;
                r_stretch   <= n_stretch;
                r_tx        <= n_tx;
                r_rx        <= n_rx;
                r_err       <= n_err;
                r_stop      <= n_stop;
                r_drive     <= n_drive;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

>>> design/i2c_master_byte_engine_unit.sv
// i2c_master_byte_engine_unit: top level of the i2c master byte engine
// depends on i2cbe_pkg, i2cbe_front, i2cbe_queue, i2cbe_core
//
// each transfer on the s_axis channel is one timing tick: a command (taken only
// while the engine is idle), the byte to send, the stop flag and the sampled
// scl/sda levels. every tick yields exactly one transfer on m_axis carrying the
// line drives and status after that tick, in order.
// the cfg channel writes half_period_ticks (index 0) or stretch_limit (index 1);
// it is always ready and is meant to be used while no tick is in flight.
// throughput is one tick per cycle while m_axis_tready stays high: the front
// decodes into a two-entry queue and the core executes one queued tick per
// cycle into an output register, which registers each result after the queue.
// when m_axis_tready is low the result holds in the output register, the core
// stops, the queue fills and s_axis_tready drops once both entries are taken.
// reset (i_rst_n low, synchronous) empties the queue and output register,
// returns the sequencer to idle with both lines released and restores the
// configuration defaults (6 ticks per half period, stretch limit 255).
module i2c_master_byte_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // cmd[2:0], tx_byte[10:3], stop_after[11], scl_in[12], sda_in[13], zero pad
    input  logic [i2cbe_pkg::TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // scl_pull_low[0], sda_pull_low[1], busy_res[2], done_res[3], success[4],
    // rx_byte[12:5], nack_seen[13], stretch_timeout[14], zero pad
    output logic [i2cbe_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import i2cbe_pkg::*;

    t_item   w_front_item;
    t_item   w_q_item;
    t_result w_result;
    logic    w_q_full;
    logic    w_q_valid;
    logic    w_pop;

    assign s_axis_tready = !w_q_full;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = {1'b0, w_result};

    i2cbe_front u_front (
        .i_tdata (s_axis_tdata),
        .o_item  (w_front_item)
    );

    i2cbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    i2cbe_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (w_result)
    );

endmodule
